// File: sv/tsac_pkg.sv
// Shared widths, constants, CORDIC angle table and beat types for the
// track slope angle change accumulator. No dependencies.
package tsac_pkg;

   localparam int COORD_W      = 20;
   localparam int DIFF_W       = COORD_W + 1;
   localparam int SQ_W         = 2 * DIFF_W;
   localparam int RAD_W        = SQ_W + 16;
   localparam int ROOT_W       = RAD_W / 2;
   localparam int ROOT_STEPS   = ROOT_W;
   localparam int RCNT_W       = $clog2(ROOT_STEPS);
   localparam int REM_W        = ROOT_W + 3;
   localparam int CORDIC_STEPS = 20;
   localparam int STEP_W       = 5;
   localparam int CW           = 40;
   localparam int TW           = 25;
   localparam int ANG_W        = 16;
   localparam int SEG_W        = 17;
   localparam int SUM_W        = 22;
   localparam int MAX_W        = 16;
   localparam int MAX_POINTS   = 64;
   localparam int PC_W         = $clog2(MAX_POINTS + 1);
   localparam int IN_DATA_W    = 64;
   localparam int OUT_DATA_W   = 88;

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
   localparam logic [23:0]      DEG90   = 24'd5898240;
   localparam logic [24:0]      DEG180  = 25'd11796480;
   localparam logic signed [SEG_W-1:0] SEG_MISSING = -17'sd256;

   typedef struct packed {
      logic                 valid;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [TW-1:0] t;
   } cordic_beat_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SQR  = 5'b00010,
      ST_ROOT = 5'b00100,
      ST_CORD = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   function automatic logic signed [TW-1:0] atan_entry(input logic [STEP_W-1:0] i);
      logic signed [TW-1:0] v;
      case (i)
         5'd0:  v = 25'sd2949120;
         5'd1:  v = 25'sd1740967;
         5'd2:  v = 25'sd919879;
         5'd3:  v = 25'sd466945;
         5'd4:  v = 25'sd234379;
         5'd5:  v = 25'sd117304;
         5'd6:  v = 25'sd58666;
         5'd7:  v = 25'sd29335;
         5'd8:  v = 25'sd14668;
         5'd9:  v = 25'sd7334;
         5'd10: v = 25'sd3667;
         5'd11: v = 25'sd1833;
         5'd12: v = 25'sd917;
         5'd13: v = 25'sd458;
         5'd14: v = 25'sd229;
         5'd15: v = 25'sd115;
         5'd16: v = 25'sd57;
         5'd17: v = 25'sd29;
         5'd18: v = 25'sd14;
         5'd19: v = 25'sd7;
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic [ANG_W-1:0] finish_angle(input logic signed [TW-1:0] t,
                                                     input logic neg);
      logic [23:0] c;
      logic [24:0] u;
      logic [24:0] r;
      if (t < 0) begin
         c = '0;
      end else if (t > $signed({1'b0, DEG90})) begin
         c = DEG90;
      end else begin
         c = t[23:0];
      end
      u = neg ? (DEG180 - {1'b0, c}) : {1'b0, c};
      r = u + 25'd128;
      return r[23:8];
   endfunction

endpackage

// File: sv/tsac_sqrt.sv
// Bit-serial integer square root, two radicand bits per cycle.
// Depends on tsac_pkg.
module tsac_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tsac_pkg::RAD_W-1:0]    radicand,
   output logic                          done,
   output logic [tsac_pkg::ROOT_W-1:0]   root
);
   import tsac_pkg::*;

   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [RCNT_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [REM_W-1:0]  rem_sh;
   logic [REM_W-1:0]  trial;

   always_comb begin
      rem_sh  = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
      trial   = {{(REM_W-ROOT_W-2){1'b0}}, root_ff, 2'b01};
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == RCNT_W'(ROOT_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// File: sv/tsac_cordic_cell.sv
// One CORDIC vectoring iteration, registered; cells chain into a pipeline.
// Depends on tsac_pkg.
module tsac_cordic_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [tsac_pkg::STEP_W-1:0]     step,
   input  tsac_pkg::cordic_beat_type       beat_in,
   output tsac_pkg::cordic_beat_type       beat_out
);
   import tsac_pkg::*;

   cordic_beat_type      beat_ff, beat_in_n;
   logic signed [CW-1:0] xs;
   logic signed [CW-1:0] ys;
   logic signed [TW-1:0] ang;

   always_comb begin
      xs        = beat_in.x >>> step;
      ys        = beat_in.y >>> step;
      ang       = atan_entry(step);
      beat_in_n = beat_in;
      if (beat_in.y > 0) begin
         beat_in_n.x = beat_in.x + ys;
         beat_in_n.y = beat_in.y - xs;
         beat_in_n.t = beat_in.t + ang;
      end else if (beat_in.y < 0) begin
         beat_in_n.x = beat_in.x - ys;
         beat_in_n.y = beat_in.y + xs;
         beat_in_n.t = beat_in.t - ang;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff.x <= beat_in_n.x;
      beat_ff.y <= beat_in_n.y;
      beat_ff.t <= beat_in_n.t;
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else begin
         beat_ff.valid <= beat_in_n.valid;
      end
   end

   assign beat_out = beat_ff;

endmodule

// File: sv/track_slope_angle_change_accumulator.sv
// Top level of the track slope angle change accumulator: sequencer, two
// square-root units, a 20-cell CORDIC chain and the per-track state.
// Depends on tsac_pkg, tsac_sqrt, tsac_cordic_cell.
//
//   channel  direction  tdata (low bit up)                     tuser    tlast
//   req_     in         pos_x, pos_y, depth_z, 4 pad bits      present  track_end
//   rsp_     out        segment_angle, angle_change,           -        final_res
//                       change_sum, max_change, entry_slope
//
// Each point passes through accept, square, the square-root units (29 root steps
// and the hand-off), the CORDIC chain (two vectors, one behind the other) and
// commit; the root recurrence and the chain depth set the time a point takes.
// Reset is synchronous and clears the sequencer, track counters and valid bits.
// A stalled rsp_ holds the finished result; a new point is taken once the
// current one has been committed to the output register.
module track_slope_angle_change_accumulator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tsac_pkg::IN_DATA_W-1:0]      req_tdata,  // pos_x, pos_y, depth_z, pad
   input  logic                                req_tuser,  // present
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tsac_pkg::OUT_DATA_W-1:0]     rsp_tdata,  // seg, change, sum, max, slope
   output logic                                rsp_tlast
);
   import tsac_pkg::*;

   state_type state_ff, state_in;

   logic [COORD_W-1:0] cur_x_ff, cur_y_ff, cur_z_ff;
   logic               here_ff, last_ff;
   logic [COORD_W-1:0] prev_x_ff, prev_y_ff, prev_z_ff;
   logic [COORD_W-1:0] entry_x_ff, entry_y_ff, entry_z_ff;
   logic               prev_valid_ff, entry_valid_ff;
   logic signed [SEG_W-1:0] prev_seg_ff;
   logic [PC_W-1:0]    pc_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [MAX_W-1:0]   max_ff;

   logic [COORD_W-1:0] az_p_ff, az_e_ff;
   logic               neg_p_ff, neg_e_ff;
   logic [1:0]         feed_ff;
   logic               got_ff;
   logic [ANG_W-1:0]   ang_p_ff;
   logic [ANG_W-1:0]   ang_e_ff;

   logic                  rsp_valid_ff;
   logic [OUT_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_last_ff;

   logic signed [DIFF_W-1:0] dx_p, dy_p, dz_p, dx_e, dy_e, dz_e;
   logic signed [SQ_W-1:0]   sqx_p, sqy_p, sqx_e, sqy_e;
   logic [SQ_W-1:0]          s_p, s_e;
   logic [DIFF_W-1:0]        az_p, az_e;
   logic [RAD_W-1:0]         rad_p, rad_e;
   logic                     root_start, done_p, done_e;
   logic [ROOT_W-1:0]        root_p, root_e;

   cordic_beat_type chain [0:CORDIC_STEPS];
   cordic_beat_type head;

   logic                    in_fire, out_fire;
   logic signed [SEG_W-1:0] seg, change;
   logic [SEG_W-1:0]        mag;
   logic [SUM_W:0]          sum_wide;
   logic [SUM_W-1:0]        sum_next;
   logic [MAX_W-1:0]        max_next;
   logic [ANG_W-1:0]        slope;
   logic [ANG_W-1:0]        ang_cur;

   assign in_fire    = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign out_fire   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      dx_p  = $signed({cur_x_ff[COORD_W-1], cur_x_ff}) - $signed({prev_x_ff[COORD_W-1], prev_x_ff});
      dy_p  = $signed({cur_y_ff[COORD_W-1], cur_y_ff}) - $signed({prev_y_ff[COORD_W-1], prev_y_ff});
      dz_p  = $signed({1'b0, cur_z_ff}) - $signed({1'b0, prev_z_ff});
      dx_e  = $signed({cur_x_ff[COORD_W-1], cur_x_ff})
            - $signed({entry_x_ff[COORD_W-1], entry_x_ff});
      dy_e  = $signed({cur_y_ff[COORD_W-1], cur_y_ff})
            - $signed({entry_y_ff[COORD_W-1], entry_y_ff});
      dz_e  = $signed({1'b0, cur_z_ff}) - $signed({1'b0, entry_z_ff});
      sqx_p = dx_p * dx_p;
      sqy_p = dy_p * dy_p;
      sqx_e = dx_e * dx_e;
      sqy_e = dy_e * dy_e;
      s_p   = $unsigned(sqx_p) + $unsigned(sqy_p);
      s_e   = $unsigned(sqx_e) + $unsigned(sqy_e);
      rad_p = {s_p, 16'b0};
      rad_e = {s_e, 16'b0};
      az_p  = dz_p[DIFF_W-1] ? $unsigned(-dz_p) : $unsigned(dz_p);
      az_e  = dz_e[DIFF_W-1] ? $unsigned(-dz_e) : $unsigned(dz_e);
   end

   assign root_start = (state_ff == ST_SQR);

   tsac_sqrt u_sqrt_p (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (rad_p),
      .done     (done_p),
      .root     (root_p)
   );

   tsac_sqrt u_sqrt_e (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (rad_e),
      .done     (done_e),
      .root     (root_e)
   );

   always_comb begin
      head.valid = (state_ff == ST_CORD) && !feed_ff[1];
      head.t     = '0;
      if (feed_ff[0]) begin
         head.x = $signed({{(CW-COORD_W-14){1'b0}}, az_e_ff, 14'b0});
         head.y = $signed({{(CW-ROOT_W-6){1'b0}}, root_e, 6'b0});
      end else begin
         head.x = $signed({{(CW-COORD_W-14){1'b0}}, az_p_ff, 14'b0});
         head.y = $signed({{(CW-ROOT_W-6){1'b0}}, root_p, 6'b0});
      end
   end

   assign chain[0] = head;

   genvar g;
   generate
      for (g = 0; g < CORDIC_STEPS; g++) begin : g_cell
         tsac_cordic_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .step     (STEP_W'(g)),
            .beat_in  (chain[g]),
            .beat_out (chain[g+1])
         );
      end
   endgenerate

   assign ang_cur = finish_angle(chain[CORDIC_STEPS].t, got_ff ? neg_e_ff : neg_p_ff);

   always_comb begin
      if (pc_ff == '0) begin
         seg = '0;
      end else if (prev_valid_ff && here_ff) begin
         seg = $signed({1'b0, ang_p_ff});
      end else begin
         seg = SEG_MISSING;
      end
      change   = (pc_ff >= PC_W'(2)) ? (seg - prev_seg_ff) : '0;
      mag      = change[SEG_W-1] ? $unsigned(-change) : $unsigned(change);
      sum_wide = {1'b0, sum_ff} + {{(SUM_W+1-SEG_W){1'b0}}, mag};
      sum_next = (sum_wide > {1'b0, SUM_MAX}) ? SUM_MAX : sum_wide[SUM_W-1:0];
      max_next = (mag[MAX_W-1:0] > max_ff) ? mag[MAX_W-1:0] : max_ff;
      slope    = ((pc_ff != '0) && entry_valid_ff && here_ff) ? ang_e_ff : '0;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (in_fire) state_in = ST_SQR;
         ST_SQR:  state_in = ST_ROOT;
         ST_ROOT: if (done_p) state_in = ST_CORD;
         ST_CORD: if (chain[CORDIC_STEPS].valid && got_ff) state_in = ST_DONE;
         ST_DONE: if (out_fire) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         cur_x_ff <= req_tdata[COORD_W-1:0];
         cur_y_ff <= req_tdata[2*COORD_W-1:COORD_W];
         cur_z_ff <= req_tdata[3*COORD_W-1:2*COORD_W];
         here_ff  <= req_tuser;
         last_ff  <= req_tlast;
      end
      if (state_ff == ST_SQR) begin
         az_p_ff  <= az_p[COORD_W-1:0];
         az_e_ff  <= az_e[COORD_W-1:0];
         neg_p_ff <= dz_p[DIFF_W-1];
         neg_e_ff <= dz_e[DIFF_W-1];
      end
      if (chain[CORDIC_STEPS].valid) begin
         if (got_ff) begin
            ang_e_ff <= ang_cur;
         end else begin
            ang_p_ff <= ang_cur;
         end
      end
      if (out_fire) begin
         rsp_data_ff <= {slope, max_next, sum_next, change, seg};
         rsp_last_ff <= last_ff;
         prev_x_ff   <= cur_x_ff;
         prev_y_ff   <= cur_y_ff;
         prev_z_ff   <= cur_z_ff;
         prev_seg_ff <= seg;
         if (pc_ff == '0) begin
            entry_x_ff <= cur_x_ff;
            entry_y_ff <= cur_y_ff;
            entry_z_ff <= cur_z_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         feed_ff        <= '0;
         got_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         pc_ff          <= '0;
         sum_ff         <= '0;
         max_ff         <= '0;
         prev_valid_ff  <= 1'b0;
         entry_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CORD) begin
            if (!feed_ff[1]) begin
               feed_ff <= feed_ff + 2'd1;
            end
            if (chain[CORDIC_STEPS].valid) begin
               got_ff <= !got_ff;
            end
         end else begin
            feed_ff <= '0;
            got_ff  <= 1'b0;
         end
         if (out_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (out_fire) begin
            if (last_ff) begin
               pc_ff          <= '0;
               sum_ff         <= '0;
               max_ff         <= '0;
               prev_valid_ff  <= 1'b0;
               entry_valid_ff <= 1'b0;
            end else begin
               if (pc_ff < PC_W'(MAX_POINTS)) begin
                  pc_ff <= pc_ff + 1'b1;
               end
               sum_ff        <= sum_next;
               max_ff        <= max_next;
               prev_valid_ff <= here_ff;
               if (pc_ff == '0) begin
                  entry_valid_ff <= here_ff;
               end
            end
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_chain_in_cord: assert property (@(posedge clock) disable iff (reset)
      chain[CORDIC_STEPS].valid |-> state_ff == ST_CORD)
      else $error("cordic result outside cordic phase");
   a_root_in_root: assert property (@(posedge clock) disable iff (reset)
      (done_p || done_e) |-> (state_ff == ST_ROOT && done_p && done_e))
      else $error("square-root units out of step");
   a_pc_bound: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= PC_W'(MAX_POINTS))
      else $error("point count past limit");
   a_track_clear: assert property (@(posedge clock) disable iff (reset)
      (out_fire && last_ff) |=> (pc_ff == '0 && sum_ff == '0 && max_ff == '0))
      else $error("track state not cleared after last beat");
   a_max_le_sum: assert property (@(posedge clock) disable iff (reset)
      {{(SUM_W-MAX_W){1'b0}}, max_ff} <= sum_ff)
      else $error("max change above change sum");
`endif

endmodule

// File: bench/track_slope_angle_change_accumulator_tb.sv
// Self-checking bench for the track slope angle change accumulator: drives track
// points on req_, predicts each result beat and compares it on rsp_.
// Depends on tsac_pkg and the block's RTL.
module track_slope_angle_change_accumulator_tb;
   import tsac_pkg::*;

   typedef struct packed {
      logic [15:0]        slope;
      logic [15:0]        maxc;
      logic [21:0]        sum;
      logic signed [16:0] change;
      logic signed [16:0] seg;
      logic               fin;
   } track_result_type;

   logic clock, reset;
   logic req_tvalid, req_tready, req_tuser, req_tlast;
   logic [IN_DATA_W-1:0] req_tdata;
   logic rsp_tvalid, rsp_tready, rsp_tlast;
   logic [OUT_DATA_W-1:0] rsp_tdata;

   track_slope_angle_change_accumulator uut (.*);

   localparam longint ATAN_TABLE [20] = '{2949120, 1740967, 919879, 466945, 234379,
      117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};

   longint ent_x, ent_y, ent_z, prv_x, prv_y, prv_z, prv_seg;
   bit ent_ok, prv_ok;
   int pts_seen;
   longint sum_abs, max_abs;
   track_result_type pending_results[$];
   int error_count;
   bit hold_off;

   function automatic longint int_sqrt(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic longint polar_deg(longint x0, longint y0, longint z0,
                                        longint x1, longint y1, longint z1);
      longint dx, dy, dz, r, a, cx, cy, t, nx;
      dx = x1 - x0;
      dy = y1 - y0;
      dz = z1 - z0;
      r = int_sqrt((dx * dx + dy * dy) << 16);
      a = (dz < 0 ? -dz : dz) << 8;
      t = 0;
      if (r == 0 && a == 0) return 0;
      cx = a << 6;
      cy = r << 6;
      for (int i = 0; i < 20; i++) begin
         nx = cx;
         if (cy > 0) begin
            nx = cx + (cy >>> i);
            cy = cy - (cx >>> i);
            t += ATAN_TABLE[i];
         end else if (cy < 0) begin
            nx = cx - (cy >>> i);
            cy = cy + (cx >>> i);
            t -= ATAN_TABLE[i];
         end
         cx = nx;
      end
      if (t < 0) t = 0;
      if (t > 90 * 65536) t = 90 * 65536;
      if (dz < 0) t = 180 * 65536 - t;
      return (t + 128) >>> 8;
   endfunction

   task automatic clear_track();
      ent_x = 0; ent_y = 0; ent_z = 0; ent_ok = 0;
      prv_x = 0; prv_y = 0; prv_z = 0; prv_ok = 0; prv_seg = 0;
      pts_seen = 0; sum_abs = 0; max_abs = 0;
   endtask

   task automatic predict_point(logic signed [19:0] px, logic signed [19:0] py,
                                logic [19:0] pz, bit here, bit last);
      longint x, y, z, seg, change, mag, slope;
      track_result_type e;
      x = px; y = py; z = pz;
      seg = 0; change = 0; slope = 0;
      if (pts_seen == 0) begin
         ent_x = x; ent_y = y; ent_z = z; ent_ok = here;
      end else begin
         seg = (prv_ok && here) ? polar_deg(prv_x, prv_y, prv_z, x, y, z) : -256;
         if (pts_seen >= 2) begin
            change = seg - prv_seg;
            mag = change < 0 ? -change : change;
            sum_abs = (sum_abs + mag > 4194303) ? 4194303 : sum_abs + mag;
            if (mag > max_abs) max_abs = mag;
         end
         if (ent_ok && here) slope = polar_deg(ent_x, ent_y, ent_z, x, y, z);
      end
      e.seg = 17'(seg); e.change = 17'(change); e.sum = 22'(sum_abs);
      e.maxc = 16'(max_abs); e.slope = 16'(slope); e.fin = last;
      pending_results.push_back(e);
      prv_x = x; prv_y = y; prv_z = z; prv_ok = here; prv_seg = seg;
      if (pts_seen < MAX_POINTS) pts_seen++;
      if (last) clear_track();
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   task automatic send_point(logic signed [19:0] px, logic signed [19:0] py,
                             logic [19:0] pz, bit here, bit last);
      if ($urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 60)
                                           : $urandom_range(1, 3)) @(negedge clock);
      end
      req_tdata <= {4'b0, pz, py, px};
      req_tuser <= here;
      req_tlast <= last;
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_point(px, py, pz, here, last);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      track_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.seg = rsp_tdata[16:0];
         got.change = rsp_tdata[33:17];
         got.sum = rsp_tdata[55:34];
         got.maxc = rsp_tdata[71:56];
         got.slope = rsp_tdata[87:72];
         got.fin = rsp_tlast;
         if (pending_results.size() == 0) begin
            $display("unexpected result beat");
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.seg != want.seg) report_mismatch("segment_angle", got.seg, want.seg);
            if (got.change != want.change)
               report_mismatch("angle_change", got.change, want.change);
            if (got.sum != want.sum) report_mismatch("change_sum", got.sum, want.sum);
            if (got.maxc != want.maxc) report_mismatch("max_change", got.maxc, want.maxc);
            if (got.slope != want.slope)
               report_mismatch("entry_slope", got.slope, want.slope);
            if (got.fin != want.fin) report_mismatch("final_res", got.fin, want.fin);
         end
      end
   end

   initial begin
      int gap;
      rsp_tready = 0;
      @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_tready <= 0;
            repeat (400) @(negedge clock);
            hold_off = 0;
         end
         gap = $urandom_range(0, 9);
         rsp_tready <= (gap > 2);
         if (gap == 0) begin
            repeat ($urandom_range(5, 80)) @(negedge clock);
         end
         @(negedge clock);
      end
   end

   task automatic test_extremes();
      send_point(-20'sd524288, -20'sd524288, 20'd0, 1, 0);
      send_point(20'sd524287, 20'sd524287, 20'hFFFFF, 1, 0);
      send_point(-20'sd524288, 20'sd524287, 20'd0, 1, 0);
      send_point(20'sd524287, 20'sd524287, 20'd0, 1, 0);
      send_point(20'sd524287, 20'sd524287, 20'd0, 1, 0);
      send_point(20'sd524287, 20'sd524287, 20'd5000, 1, 1);
   endtask

   task automatic test_missing_points();
      send_point(0, 0, 0, 0, 0);
      send_point(100, 50, 1000, 1, 0);
      send_point(120, 40, 2000, 0, 0);
      send_point(120, 40, 1500, 1, 0);
      send_point(200, 40, 500, 1, 1);
      send_point(5, 5, 5, 1, 1);
      send_point(5, 5, 5, 0, 1);
   endtask

   task automatic test_long_saturating_track();
      for (int i = 0; i < 80; i++)
         send_point(i[0] ? 20'sd524287 : -20'sd524288, 0, i[0] ? 20'd0 : 20'd10,
                    (i % 3) != 2, i == 79);
   endtask

   task automatic test_backpressure();
      hold_off = 1;
      for (int i = 0; i < 6; i++)
         send_point(20'($urandom), 20'($urandom), 20'($urandom), 1, i == 5);
   endtask

   task automatic test_random_tracks();
      int n, len, spread;
      logic signed [19:0] x, y;
      logic [19:0] z;
      n = 0;
      while (n < 1100) begin
         len = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 75) : $urandom_range(1, 12);
         spread = $urandom_range(0, 3);
         x = 20'($urandom); y = 20'($urandom); z = 20'($urandom);
         for (int i = 0; i < len; i++) begin
            if (spread == 0) begin
               x = 20'($urandom); y = 20'($urandom); z = 20'($urandom);
            end else begin
               x = x + 20'($urandom_range(0, 2000)) - 20'd1000;
               y = y + 20'($urandom_range(0, 2000)) - 20'd1000;
               z = z + 20'((spread == 3) ? $urandom_range(0, 3) : $urandom_range(0, 6000));
            end
            send_point(x, y, z, $urandom_range(0, 7) != 0, i == len - 1);
            n++;
         end
      end
   endtask

   initial begin
      error_count = 0;
      hold_off = 0;
      clear_track();
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = 0;
      req_tlast = 0;
      repeat (10) @(negedge clock);
      reset = 0;
      test_extremes();
      test_missing_points();
      test_backpressure();
      test_long_saturating_track();
      test_random_tracks();
      req_tvalid <= 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("simulation failed");
      $finish;
   end
endmodule

// File: filelist.f
sv/tsac_pkg.sv
sv/tsac_sqrt.sv
sv/tsac_cordic_cell.sv
sv/track_slope_angle_change_accumulator.sv
bench/track_slope_angle_change_accumulator_tb.sv
